// File: design/ttlpd_pkg.sv
// ----------------------------------------------------------------------------
// ttlpd_pkg
// Shared types, codes and reset values of the two-type length-prefixed
// deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package ttlpd_pkg;

  // Depth of the header store, the largest header in bytes.
  localparam int unsigned HEADER_MAX_DEF = 64;

  // Fixed offsets inside a header.
  localparam int unsigned UPD_LEN_OFS  = 32;
  localparam int unsigned CMD_LEN_OFS  = 12;
  localparam int unsigned CMD_TYPE_OFS = 2;

  // Lower bounds of the header lengths.
  localparam logic [6:0] UPD_HLEN_MIN = 7'd36;
  localparam logic [6:0] CMD_HLEN_MIN = 7'd16;

  // Configuration register indexes.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_UPDATE_MAGIC        = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_UPDATE_HEADER_LEN   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_COMMAND_HEADER_LEN  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_UPDATE_PAYLOAD_MAX  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_COMMAND_PAYLOAD_MAX = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_DISCONNECT_CODE     = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_BIG_ENDIAN          = 3'd6;

  // Frame kinds.
  localparam logic [1:0] KIND_LOGIN  = 2'd0;
  localparam logic [1:0] KIND_DISC   = 2'd1;
  localparam logic [1:0] KIND_UPDATE = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_DATA     = 2'd0;
  localparam logic [1:0] STAT_TOO_LONG = 2'd1;
  localparam logic [1:0] STAT_FAILED   = 2'd2;

  typedef struct packed {
    logic [15:0] update_magic;
    logic [6:0]  update_header_len;
    logic [6:0]  command_header_len;
    logic [31:0] update_payload_max;
    logic [31:0] command_payload_max;
    logic [15:0] disconnect_code;
    logic        big_endian;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    update_magic:        16'd0,
    update_header_len:   7'd36,
    command_header_len:  7'd16,
    update_payload_max:  32'd65536,
    command_payload_max: 32'd65536,
    disconnect_code:     16'd0,
    big_endian:          1'b1
  };

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_CHECK,
    ST_EMIT_RD,
    ST_EMIT_WR,
    ST_PAYLOAD,
    ST_FAILED
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;     // drop held header, kind and payload count
    logic hdr_wr;    // store one header byte
    logic latch;     // header complete: take kind, payload length, reset sweep
    logic ld_fail;   // load a too-long result
    logic rd_issue;  // read the header byte at the sweep index
    logic ld_emit;   // load a header byte result and advance the sweep
    logic ld_pay;    // load a payload byte result
    logic ld_stuck;  // load an already-failed result
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;        // output register can take a result this cycle
    logic hdr_incomplete;  // held bytes do not yet form a whole header
    logic too_long;        // payload length above the maximum of its kind
    logic emit_last;       // sweep index is on the last held byte
    logic pay_last;        // one payload byte left
    logic plen_zero;       // latched payload length is zero
  } dp_sts_t;

endpackage

`default_nettype wire

// File: design/ttlpd_cfg.sv
// ----------------------------------------------------------------------------
// ttlpd_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module ttlpd_cfg (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  cfg_we,
  input  wire [ttlpd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  wire [31:0]                           cfg_wdata,
  output ttlpd_pkg::cfg_t                      cfg
);

  ttlpd_pkg::cfg_t cfg_r;
  ttlpd_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        ttlpd_pkg::CFG_UPDATE_MAGIC:        cfg_nxt.update_magic = cfg_wdata[15:0];
        ttlpd_pkg::CFG_UPDATE_HEADER_LEN:   cfg_nxt.update_header_len = cfg_wdata[6:0];
        ttlpd_pkg::CFG_COMMAND_HEADER_LEN:  cfg_nxt.command_header_len = cfg_wdata[6:0];
        ttlpd_pkg::CFG_UPDATE_PAYLOAD_MAX:  cfg_nxt.update_payload_max = cfg_wdata;
        ttlpd_pkg::CFG_COMMAND_PAYLOAD_MAX: cfg_nxt.command_payload_max = cfg_wdata;
        ttlpd_pkg::CFG_DISCONNECT_CODE:     cfg_nxt.disconnect_code = cfg_wdata[15:0];
        ttlpd_pkg::CFG_BIG_ENDIAN:          cfg_nxt.big_endian = cfg_wdata[0];
        default:                            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= ttlpd_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: design/ttlpd_ctrl.sv
// ----------------------------------------------------------------------------
// ttlpd_ctrl
// Controller state machine: collects the header, checks it, sweeps it out
// and then passes the payload or holds the failure.
// ----------------------------------------------------------------------------
`default_nettype none

module ttlpd_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  input  wire                  in_func,
  output logic                 in_tready,
  input  ttlpd_pkg::dp_sts_t   sts,
  output ttlpd_pkg::dp_cmd_t   cmd
);

  ttlpd_pkg::state_t state_r;
  ttlpd_pkg::state_t state_nxt;
  logic              acc;

  always_comb begin
    unique case (state_r)
      ttlpd_pkg::ST_COLLECT: in_tready = 1'b1;
      ttlpd_pkg::ST_PAYLOAD: in_tready = sts.out_free;
      ttlpd_pkg::ST_FAILED:  in_tready = sts.out_free;
      default:               in_tready = 1'b0;
    endcase
  end

  assign acc = in_tvalid & in_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ttlpd_pkg::ST_COLLECT: begin
        if (acc && !in_func) state_nxt = ttlpd_pkg::ST_CHECK;
      end
      ttlpd_pkg::ST_CHECK: begin
        priority if (sts.hdr_incomplete) state_nxt = ttlpd_pkg::ST_COLLECT;
        else if (sts.too_long) begin
          if (sts.out_free) state_nxt = ttlpd_pkg::ST_FAILED;
        end else state_nxt = ttlpd_pkg::ST_EMIT_RD;
      end
      ttlpd_pkg::ST_EMIT_RD: state_nxt = ttlpd_pkg::ST_EMIT_WR;
      ttlpd_pkg::ST_EMIT_WR: begin
        if (sts.out_free) begin
          priority if (!sts.emit_last) state_nxt = ttlpd_pkg::ST_EMIT_RD;
          else if (sts.plen_zero)      state_nxt = ttlpd_pkg::ST_COLLECT;
          else                         state_nxt = ttlpd_pkg::ST_PAYLOAD;
        end
      end
      ttlpd_pkg::ST_PAYLOAD: begin
        if (acc && (in_func || sts.pay_last)) state_nxt = ttlpd_pkg::ST_COLLECT;
      end
      ttlpd_pkg::ST_FAILED: begin
        if (acc && in_func) state_nxt = ttlpd_pkg::ST_COLLECT;
      end
      default: state_nxt = ttlpd_pkg::ST_COLLECT;
    endcase
  end

  // Commands.
  always_comb begin
    cmd = '0;
    unique case (state_r)
      ttlpd_pkg::ST_COLLECT: begin
        cmd.clear  = acc & in_func;
        cmd.hdr_wr = acc & ~in_func;
      end
      ttlpd_pkg::ST_CHECK: begin
        cmd.latch   = ~sts.hdr_incomplete & (~sts.too_long | sts.out_free);
        cmd.ld_fail = ~sts.hdr_incomplete & sts.too_long & sts.out_free;
      end
      ttlpd_pkg::ST_EMIT_RD: cmd.rd_issue = 1'b1;
      ttlpd_pkg::ST_EMIT_WR: cmd.ld_emit = sts.out_free;
      ttlpd_pkg::ST_PAYLOAD: begin
        cmd.clear  = acc & in_func;
        cmd.ld_pay = acc & ~in_func;
      end
      ttlpd_pkg::ST_FAILED: begin
        cmd.clear    = acc & in_func;
        cmd.ld_stuck = acc & ~in_func;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ttlpd_pkg::ST_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/ttlpd_dp.sv
// ----------------------------------------------------------------------------
// ttlpd_dp
// Datapath: header store, header decode, payload counter and the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module ttlpd_dp #(
  parameter int unsigned HEADER_MAX = ttlpd_pkg::HEADER_MAX_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  ttlpd_pkg::cfg_t      cfg,
  input  ttlpd_pkg::dp_cmd_t   cmd,
  output ttlpd_pkg::dp_sts_t   sts,
  input  wire  [7:0]           in_byte,
  output logic                 out_tvalid,
  input  wire                  out_tready,
  output logic [7:0]           out_byte,
  output logic [1:0]           frame_kind,
  output logic                 first_of_frame,
  output logic                 last_of_frame,
  output logic [1:0]           status,
  output logic                 bytes_pending
);

  localparam int unsigned IDX_W = $clog2(HEADER_MAX);
  localparam int unsigned CNT_W = $clog2(HEADER_MAX + 1);
  localparam int unsigned CMP_W = (CNT_W > 7) ? CNT_W : 7;
  localparam logic [CMP_W-1:0] HMAX_C = CMP_W'(HEADER_MAX);

  logic [7:0]       mem [HEADER_MAX];
  logic [7:0]       mem_q_r;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] idx_r;
  logic [31:0]      payload_left_r;
  logic [1:0]       kind_r;

  // Copies of the header bytes the decode needs.
  logic [7:0]       b0_r, b1_r, b2_r, b3_r;
  logic [7:0]       c12_r, c13_r, c14_r, c15_r;
  logic [7:0]       u32_r, u33_r, u34_r, u35_r;

  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic [1:0]       out_kind_r;
  logic             out_first_r;
  logic             out_last_r;
  logic [1:0]       out_status_r;
  logic             out_pend_r;

  logic [15:0]      magic16;
  logic [15:0]      type16;
  logic             is_upd;
  logic             is_disc;
  logic [CMP_W-1:0] hl_upd_raw, hl_cmd_raw;
  logic [CMP_W-1:0] hlen_upd, hlen_cmd, hlen_sel;
  logic [CMP_W-1:0] count_ext;
  logic [31:0]      plen_upd, plen_cmd, plen_sel, pmax_sel;
  logic [1:0]       kind_now;
  logic [1:0]       kind_held;
  logic             out_free;
  logic             emit_last;
  logic             load;

  function automatic logic [CMP_W-1:0] clamp_len(input logic [CMP_W-1:0] v,
                                                 input logic [CMP_W-1:0] lo);
    logic [CMP_W-1:0] r;
    if (v < lo) r = lo;
    else if (v > HMAX_C) r = HMAX_C;
    else r = v;
    return r;
  endfunction

  // Header decode.
  assign magic16 = cfg.big_endian ? {b0_r, b1_r} : {b1_r, b0_r};
  assign type16  = cfg.big_endian ? {b2_r, b3_r} : {b3_r, b2_r};
  assign is_upd  = (magic16 == cfg.update_magic);
  assign is_disc = (type16 == cfg.disconnect_code);

  assign hl_upd_raw = CMP_W'(cfg.update_header_len);
  assign hl_cmd_raw = CMP_W'(cfg.command_header_len);
  assign hlen_upd   = clamp_len(hl_upd_raw, CMP_W'(ttlpd_pkg::UPD_HLEN_MIN));
  assign hlen_cmd   = clamp_len(hl_cmd_raw, CMP_W'(ttlpd_pkg::CMD_HLEN_MIN));
  assign hlen_sel   = is_upd ? hlen_upd : hlen_cmd;
  assign count_ext  = CMP_W'(count_r);

  assign plen_upd = cfg.big_endian ? {u32_r, u33_r, u34_r, u35_r}
                                   : {u35_r, u34_r, u33_r, u32_r};
  assign plen_cmd = cfg.big_endian ? {c12_r, c13_r, c14_r, c15_r}
                                   : {c15_r, c14_r, c13_r, c12_r};
  assign plen_sel = is_upd ? plen_upd : plen_cmd;
  assign pmax_sel = is_upd ? cfg.update_payload_max : cfg.command_payload_max;

  assign kind_now = is_upd ? ttlpd_pkg::KIND_UPDATE
                           : (is_disc ? ttlpd_pkg::KIND_DISC : ttlpd_pkg::KIND_LOGIN);

  // Kind reported while failed: the disconnect type counts only once a whole
  // command header is held.
  always_comb begin
    priority if (count_r < CNT_W'(2)) kind_held = kind_r;
    else if (is_upd)                  kind_held = ttlpd_pkg::KIND_UPDATE;
    else if (count_ext >= hlen_cmd && is_disc) kind_held = ttlpd_pkg::KIND_DISC;
    else                              kind_held = ttlpd_pkg::KIND_LOGIN;
  end

  assign out_free  = ~out_valid_r | out_tready;
  assign emit_last = (idx_r + CNT_W'(1)) == count_r;
  assign load      = cmd.ld_fail | cmd.ld_emit | cmd.ld_pay | cmd.ld_stuck;

  assign sts.out_free       = out_free;
  assign sts.hdr_incomplete = (count_r < CNT_W'(2)) | (count_ext < hlen_sel);
  assign sts.too_long       = plen_sel > pmax_sel;
  assign sts.emit_last      = emit_last;
  assign sts.pay_last       = (payload_left_r == 32'd1);
  assign sts.plen_zero      = (payload_left_r == 32'd0);

  // Header store and the decode copies.
  always_ff @(posedge clk) begin
    if (cmd.hdr_wr && (count_r < CNT_W'(HEADER_MAX))) begin
      mem[count_r[IDX_W-1:0]] <= in_byte;
      if (count_r == CNT_W'(0)) b0_r <= in_byte;
      if (count_r == CNT_W'(1)) b1_r <= in_byte;
      if (count_r == CNT_W'(ttlpd_pkg::CMD_TYPE_OFS))     b2_r  <= in_byte;
      if (count_r == CNT_W'(ttlpd_pkg::CMD_TYPE_OFS + 1)) b3_r  <= in_byte;
      if (count_r == CNT_W'(ttlpd_pkg::CMD_LEN_OFS))      c12_r <= in_byte;
      if (count_r == CNT_W'(ttlpd_pkg::CMD_LEN_OFS + 1))  c13_r <= in_byte;
      if (count_r == CNT_W'(ttlpd_pkg::CMD_LEN_OFS + 2))  c14_r <= in_byte;
      if (count_r == CNT_W'(ttlpd_pkg::CMD_LEN_OFS + 3))  c15_r <= in_byte;
      if (count_r == CNT_W'(ttlpd_pkg::UPD_LEN_OFS))      u32_r <= in_byte;
      if (count_r == CNT_W'(ttlpd_pkg::UPD_LEN_OFS + 1))  u33_r <= in_byte;
      if (count_r == CNT_W'(ttlpd_pkg::UPD_LEN_OFS + 2))  u34_r <= in_byte;
      if (count_r == CNT_W'(ttlpd_pkg::UPD_LEN_OFS + 3))  u35_r <= in_byte;
    end
    if (cmd.rd_issue) begin
      mem_q_r <= mem[idx_r[IDX_W-1:0]];
    end
  end

  // Frame state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r        <= '0;
      idx_r          <= '0;
      payload_left_r <= '0;
      kind_r         <= ttlpd_pkg::KIND_LOGIN;
    end else begin
      if (cmd.clear) begin
        count_r        <= '0;
        payload_left_r <= '0;
        kind_r         <= ttlpd_pkg::KIND_LOGIN;
      end
      if (cmd.hdr_wr && (count_r < CNT_W'(HEADER_MAX))) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.latch) begin
        kind_r         <= kind_now;
        payload_left_r <= plen_sel;
        idx_r          <= '0;
      end
      if (cmd.ld_emit) begin
        idx_r <= idx_r + CNT_W'(1);
        if (emit_last) count_r <= '0;
      end
      if (cmd.ld_pay) begin
        payload_left_r <= payload_left_r - 32'd1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_fail) begin
      out_byte_r   <= 8'd0;
      out_kind_r   <= kind_now;
      out_first_r  <= 1'b0;
      out_last_r   <= 1'b0;
      out_status_r <= ttlpd_pkg::STAT_TOO_LONG;
      out_pend_r   <= 1'b1;
    end
    if (cmd.ld_emit) begin
      out_byte_r   <= mem_q_r;
      out_kind_r   <= kind_r;
      out_first_r  <= (idx_r == CNT_W'(0));
      out_last_r   <= emit_last & sts.plen_zero;
      out_status_r <= ttlpd_pkg::STAT_DATA;
      out_pend_r   <= ~(emit_last & sts.plen_zero);
    end
    if (cmd.ld_pay) begin
      out_byte_r   <= in_byte;
      out_kind_r   <= kind_r;
      out_first_r  <= 1'b0;
      out_last_r   <= sts.pay_last;
      out_status_r <= ttlpd_pkg::STAT_DATA;
      out_pend_r   <= ~sts.pay_last;
    end
    if (cmd.ld_stuck) begin
      out_byte_r   <= 8'd0;
      out_kind_r   <= kind_held;
      out_first_r  <= 1'b0;
      out_last_r   <= 1'b0;
      out_status_r <= ttlpd_pkg::STAT_FAILED;
      out_pend_r   <= (count_r != CNT_W'(0));
    end
  end

  assign out_tvalid     = out_valid_r;
  assign out_byte       = out_byte_r;
  assign frame_kind     = out_kind_r;
  assign first_of_frame = out_first_r;
  assign last_of_frame  = out_last_r;
  assign status         = out_status_r;
  assign bytes_pending  = out_pend_r;

endmodule

`default_nettype wire

// File: design/two_type_length_prefixed_deframer.sv
// ----------------------------------------------------------------------------
// two_type_length_prefixed_deframer
// Splits a byte stream into world-update and command-response frames.
// ----------------------------------------------------------------------------
// Each input item is either a stream byte (in_tuser low) or a clear command
// (in_tuser high) that drops any held header and the failure state without
// producing an item. Header bytes are held in an internal store; each one
// is stored and then followed by a header check. Once the header is complete
// its payload length is compared with the maximum of its kind. A length
// that is too large gives one item with status "too long" and the block then
// answers every further stream byte with one "already failed" item until a
// clear arrives. A good header is swept out of the single-port store byte by
// byte (registered read, then load into the output register, which waits
// for it to free), and the payload then passes at one byte per cycle, limited
// only by the output register. Items are tagged with the frame kind and
// first/last marks; bytes_pending tells whether part of a frame is still held
// or expected. Configuration writes are taken at any time but are meant to be
// made only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module two_type_length_prefixed_deframer #(
  parameter int unsigned HEADER_MAX = ttlpd_pkg::HEADER_MAX_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // Configuration write port.
  input  wire                              cfg_we,
  input  wire [ttlpd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire [31:0]                       cfg_wdata,
  // Input stream.
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire [7:0]                        in_tdata,   // [7:0] in_byte
  input  wire [0:0]                        in_tuser,   // [0] func
  // Result stream.
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [15:0]                      out_tdata,  // [7:0] out_byte,
                                                       // [8] bytes_pending
  output logic [4:0]                       out_tuser,  // [1:0] frame_kind,
                                                       // [2] first_of_frame,
                                                       // [4:3] status
  output logic                             out_tlast   // last_of_frame
);

  ttlpd_pkg::cfg_t    cfg;
  ttlpd_pkg::dp_cmd_t cmd;
  ttlpd_pkg::dp_sts_t sts;

  logic [7:0] out_byte;
  logic [1:0] frame_kind;
  logic       first_of_frame;
  logic       last_of_frame;
  logic [1:0] status;
  logic       bytes_pending;

  ttlpd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ttlpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_func   (in_tuser[0]),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ttlpd_dp #(
    .HEADER_MAX (HEADER_MAX)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .cmd            (cmd),
    .sts            (sts),
    .in_byte        (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_byte       (out_byte),
    .frame_kind     (frame_kind),
    .first_of_frame (first_of_frame),
    .last_of_frame  (last_of_frame),
    .status         (status),
    .bytes_pending  (bytes_pending)
  );

  assign out_tdata = {7'd0, bytes_pending, out_byte};
  assign out_tuser = {status, first_of_frame, frame_kind};
  assign out_tlast = last_of_frame;

endmodule

`default_nettype wire
